FILE: rtl/core/tccw_pkg.sv
// Shared types and constants of the text console character writer.
package tccw_pkg;

    // Field widths of the request and result items
    localparam int REQ_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int NCOL_W   = 7;
    localparam int NROW_W   = 5;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int COLOUR_W = 4;
    localparam int TDATA_W  = 32;
    localparam int CFG_A_W  = 1;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_BACKGROUND = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_FOREGROUND = 1'b1;

    localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;
    localparam logic [COLOUR_W-1:0] FG_RESET = 4'hF;

    // Control characters and the printable range
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    localparam int TAB_STOP = 8;

    // White-on-black space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;   // latch the request fields
        logic exec;      // carry out the latched request
        logic copy;      // move one cell up by one row
        logic blank;     // write one blank cell of the last row
        logic clear;     // write one zero cell of the reset sweep
        logic cnt_clr;   // rewind the sweep counter
        logic load_out;  // load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic scroll;     // the latched put request runs off the last row
        logic copy_last;  // sweep counter on the last cell to copy
        logic cnt_last;   // sweep counter on the last cell of the screen
        logic out_free;   // result register can take a new result
    } dp_sts_t;

endpackage

FILE: rtl/core/tccw_ctrl.sv
// Controller state machine of the text console character writer.
module tccw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output tccw_pkg::dp_cmd_t cmd,
    input  tccw_pkg::dp_sts_t sts
);
    import tccw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.scroll) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_COPY;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_COPY: begin
                cmd.copy = 1'b1;
                if (sts.copy_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // the last copied cell is written here
            ST_DRAIN: begin
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.blank = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tccw_dp.sv
// Datapath of the text console character writer: cursor, screen memory, result register.
module tccw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tccw_pkg::dp_cmd_t                cmd,
    output tccw_pkg::dp_sts_t                sts,
    input  logic [tccw_pkg::TDATA_W-1:0]     s_tdata,
    input  logic [tccw_pkg::REQ_W-1:0]       s_tuser,
    input  logic                             cfg_wr_en,
    input  logic [tccw_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [tccw_pkg::COLOUR_W-1:0]    cfg_wr_data,
    output logic                             m_tvalid,
    output logic [tccw_pkg::TDATA_W-1:0]     m_tdata,
    input  logic                             m_tready
);
    import tccw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CW1    = COL_W + 1;
    localparam int RW1    = ROW_W + 1;

    logic [CELL_W-1:0] mem [CELLS];

    // latched request
    logic [REQ_W-1:0]  req_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [NCOL_W-1:0] ncol_reg;
    logic [NROW_W-1:0] nrow_reg;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COLOUR_W-1:0] bg_reg;
    logic [COLOUR_W-1:0] fg_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]   wadr_reg;
    logic                pend_reg;
    logic [CELL_W-1:0]   rd_data_reg;
    logic                idx_ok_reg;
    logic                scroll_reg;

    logic                m_tvalid_reg;
    logic [POS_W-1:0]    pos_out_reg;
    logic [CELL_W-1:0]   cell_out_reg;
    logic                scrolled_out_reg;

    logic [CW1-1:0]    col_wide;
    logic [RW1-1:0]    row_wide;
    logic              do_write;
    logic              scroll;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  set_col;
    logic [ROW_W-1:0]  set_row;
    logic [ADDR_W-1:0] cur_lin;
    logic              idx_ok;
    logic              is_put;
    logic              is_read;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    assign is_put  = (req_reg == REQ_PUT);
    assign is_read = (req_reg == REQ_READ);
    assign cur_lin = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign idx_ok  = (int'(idx_reg) < CELLS);

    // cursor motion of a put request
    always_comb begin
        col_wide = {1'b0, col_reg};
        row_wide = {1'b0, row_reg};
        do_write = 1'b0;
        case (char_reg) inside
            CH_BS: begin
                if (col_reg != '0) begin
                    col_wide = col_wide - 1'b1;
                end
            end
            CH_TAB: begin
                col_wide = (col_wide + CW1'(TAB_STOP)) & ~CW1'(TAB_STOP - 1);
            end
            CH_CR: begin
                col_wide = '0;
            end
            CH_LF: begin
                col_wide = '0;
                row_wide = row_wide + 1'b1;
            end
            [CH_SPACE:CH_DEL]: begin
                do_write = 1'b1;
                col_wide = col_wide + 1'b1;
            end
            default: begin
            end
        endcase
        // wrap past the last column
        if (col_wide >= CW1'(COLUMNS)) begin
            col_wide = '0;
            row_wide = row_wide + 1'b1;
        end
        scroll  = (row_wide >= RW1'(ROWS));
        put_col = COL_W'(col_wide);
        put_row = scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_wide);
    end

    assign set_col = (int'(ncol_reg) < COLUMNS) ? COL_W'(ncol_reg) : COL_W'(COLUMNS - 1);
    assign set_row = (int'(nrow_reg) < ROWS) ? ROW_W'(nrow_reg) : ROW_W'(ROWS - 1);

    // one write port, shared by sweep, copy, blanking and character writes
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cnt_reg;
        mem_wd = '0;
        if (cmd.clear) begin
            mem_we = 1'b1;
        end else if (pend_reg) begin
            mem_we = 1'b1;
            mem_wa = wadr_reg;
            mem_wd = rd_data_reg;
        end else if (cmd.blank) begin
            mem_we = 1'b1;
            mem_wd = BLANK_CELL;
        end else if (cmd.exec && is_put && do_write) begin
            mem_we = 1'b1;
            mem_wa = cur_lin;
            mem_wd = {bg_reg, fg_reg, char_reg};
        end
    end

    assign mem_re = cmd.copy || (cmd.exec && is_read && idx_ok);
    assign mem_ra = cmd.copy ? (cnt_reg + ADDR_W'(COLUMNS)) : ADDR_W'(idx_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // request fields and per-request flags
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_tuser;
            char_reg <= s_tdata[7:0];
            idx_reg  <= s_tdata[18:8];
            ncol_reg <= s_tdata[25:19];
            nrow_reg <= s_tdata[30:26];
        end
        if (cmd.exec) begin
            idx_ok_reg <= idx_ok;
            scroll_reg <= scroll;
        end
        wadr_reg <= cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bg_reg   <= BG_RESET;
            fg_reg   <= FG_RESET;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BACKGROUND: bg_reg <= cfg_wr_data;
                    CFG_FOREGROUND: fg_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.exec) begin
                if (is_put) begin
                    col_reg <= put_col;
                    row_reg <= put_row;
                end else if (req_reg == REQ_SET) begin
                    col_reg <= set_col;
                    row_reg <= set_row;
                end
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.clear || cmd.copy || cmd.blank) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // a copy read lands in rd_data_reg in the cycle after it; write it then
            pend_reg <= cmd.copy;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            pos_out_reg      <= POS_W'(cur_lin);
            cell_out_reg     <= (is_read && idx_ok_reg) ? rd_data_reg : '0;
            scrolled_out_reg <= is_put && scroll_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, scrolled_out_reg, cell_out_reg, pos_out_reg};

    assign sts.scroll    = is_put && scroll;
    assign sts.copy_last = (cnt_reg == ADDR_W'(CELLS - COLUMNS - 1));
    assign sts.cnt_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule

FILE: rtl/core/text_console_char_writer_unit.sv
// A request is captured, executed and then loaded into the output register once that register is free.
// Requests are taken one at a time: s_tready is high only in the idle state.
// A put that scrolls adds a row copy and last-row blanking, one cell per cycle
// through the single memory write port.
// Reset: aresetn is synchronous; afterwards a sweep over all COLUMNS*ROWS cells
// zeroes the screen with s_tready low; configuration writes are taken throughout.
module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: char_code[7:0], cell_index[18:8], new_column[25:19], new_row[30:26]
    input  logic [tccw_pkg::TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [tccw_pkg::REQ_W-1:0]    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: cursor_position[10:0], cell_data[26:11], scrolled[27]
    output logic [tccw_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [tccw_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [tccw_pkg::COLOUR_W-1:0] cfg_wr_data
);
    import tccw_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tready    (m_tready)
    );

endmodule

FILE: rtl/core/tccw_checker.sv
// Port-level checks of the text console character writer and their bind.
module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tccw_pkg::TDATA_W-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import tccw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
    localparam bit NARROW   = (CELLS <= 2048);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !NARROW || (int'(m_tdata[10:0]) < CELLS))
        else $error("cursor position off screen");

    // a scroll leaves the cursor on the last row and returns no cell
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |->
            (m_tdata[26:11] == '0) && (!NARROW || (int'(m_tdata[10:0]) >= LAST_ROW)))
        else $error("scroll result inconsistent");

endmodule

bind text_console_char_writer_unit tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (.*);
